// File: hdl/fcsg_pkg.sv
// Shared constants, types and lookup functions of the four-channel sound generator.
`default_nettype none
package fcsg_pkg;

  localparam int WaveRamBytes      = 16;
  localparam int SampleIntervalDef = 88;

  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpStep  = 2'd2;
  localparam logic [1:0] OpFrame = 2'd3;

  localparam logic [15:0] AddrP1Sweep = 16'hFF10;
  localparam logic [15:0] AddrP1Len   = 16'hFF11;
  localparam logic [15:0] AddrP1Env   = 16'hFF12;
  localparam logic [15:0] AddrP1Lo    = 16'hFF13;
  localparam logic [15:0] AddrP1Hi    = 16'hFF14;
  localparam logic [15:0] AddrP2Len   = 16'hFF16;
  localparam logic [15:0] AddrP2Env   = 16'hFF17;
  localparam logic [15:0] AddrP2Lo    = 16'hFF18;
  localparam logic [15:0] AddrP2Hi    = 16'hFF19;
  localparam logic [15:0] AddrWCtl    = 16'hFF1A;
  localparam logic [15:0] AddrWLen    = 16'hFF1B;
  localparam logic [15:0] AddrWLvl    = 16'hFF1C;
  localparam logic [15:0] AddrWLo     = 16'hFF1D;
  localparam logic [15:0] AddrWHi     = 16'hFF1E;
  localparam logic [15:0] AddrNLen    = 16'hFF20;
  localparam logic [15:0] AddrNEnv    = 16'hFF21;
  localparam logic [15:0] AddrNFrq    = 16'hFF22;
  localparam logic [15:0] AddrNCtl    = 16'hFF23;
  localparam logic [15:0] AddrVolume  = 16'hFF24;
  localparam logic [15:0] AddrPanning = 16'hFF25;
  localparam logic [15:0] AddrMaster  = 16'hFF26;
  localparam logic [11:0] AddrWaveRam = 12'hFF3;

  // Everything the mixer needs for one stereo sample.
  typedef struct packed {
    logic       master_on;
    logic [3:0] chan_on;
    logic [7:0] pan;
    logic [7:0] mvol;
    logic [1:0] duty0;
    logic [1:0] duty1;
    logic [2:0] pos0;
    logic [2:0] pos1;
    logic [3:0] vol0;
    logic [3:0] vol1;
    logic [3:0] vol2;
    logic [3:0] wave_nib;
    logic [1:0] wave_lvl;
    logic       noise_bit;
  } fcsg_mix_t;

  function automatic logic [6:0] noise_div(input logic [2:0] sel);
    logic [6:0] r;
    case (sel)
      3'd0: r = 7'd8;
      3'd1: r = 7'd16;
      3'd2: r = 7'd32;
      3'd3: r = 7'd48;
      3'd4: r = 7'd64;
      3'd5: r = 7'd80;
      3'd6: r = 7'd96;
      default: r = 7'd112;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] duty_mask(input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0: r = 8'h80;
      2'd1: r = 8'hC0;
      2'd2: r = 8'hF0;
      default: r = 8'h3F;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] wave_shift(input logic [1:0] sel);
    logic [2:0] r;
    case (sel)
      2'd0: r = 3'd4;
      2'd1: r = 3'd0;
      2'd2: r = 3'd1;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/four_channel_sound_generator.sv
// Top level of the four-channel sound generator: request handshake and result register.
// Usage:
//   Each input request carries op_i (0 bus read, 1 bus write, 2 machine step,
//   3 frame-sequencer tick), address_i and write_data_i. Every request yields
//   exactly one result: read_data_o for reads (0xFF for unmapped or
//   write-only addresses), and on machine steps sample_valid_o with the
//   signed left_mix_o and right_mix_o every SampleInterval steps.
//   A request is processed in the cycle it is accepted and its result sits in
//   the output register from the next cycle, so the block takes one request per
//   cycle as long as results are drained.
//   The input side is ready whenever the result register is empty or being
//   taken in the same cycle; a stalled receiver holds the result and stops
//   new requests until it is taken.
//   Reset puts every core register at its power-on value with no result pending.
//   All channel state updates go through the combinational update logic in the core.
`default_nettype none
module four_channel_sound_generator #(
  parameter int SampleInterval = fcsg_pkg::SampleIntervalDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o,
  output logic              sample_valid_o,
  output logic signed [9:0] left_mix_o,
  output logic signed [9:0] right_mix_o
);
  import fcsg_pkg::*;

  logic              fire;
  logic              out_valid_q;
  logic [7:0]        rdata_d, rdata_q;
  logic              sv_d, sv_q;
  logic signed [9:0] left_d, right_d, left_q, right_q;
  fcsg_mix_t         mix;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  fcsg_core #(.SampleInterval(SampleInterval)) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .op_i          (op_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .read_data_o   (rdata_d),
    .sample_valid_o(sv_d),
    .mix_o         (mix)
  );

  logic signed [9:0] lmix, rmix;

  fcsg_mix u_mix (
    .mix_i  (mix),
    .left_o (lmix),
    .right_o(rmix)
  );

  assign left_d  = sv_d ? lmix : 10'sd0;
  assign right_d = sv_d ? rmix : 10'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q <= rdata_d;
      sv_q    <= sv_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rdata_q;
  assign sample_valid_o = sv_q;
  assign left_mix_o     = left_q;
  assign right_mix_o    = right_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted request produced no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !sv_q) |-> (left_q == 10'sd0 && right_q == 10'sd0))
    else $error("mix without a sample");

endmodule
`default_nettype wire

// File: hdl/fcsg_mix.sv
// Stereo mixer: channel levels, panning and master volume scaling.
`default_nettype none
module fcsg_mix (
  input  fcsg_pkg::fcsg_mix_t mix_i,
  output logic signed [9:0]   left_o,
  output logic signed [9:0]   right_o
);
  import fcsg_pkg::*;

  logic signed [4:0] v [4];
  logic signed [6:0] lsum, rsum;
  logic signed [11:0] lprod, rprod;
  logic [3:0] wv;
  logic [7:0] m0, m1;

  always_comb begin
    m0 = duty_mask(mix_i.duty0) >> mix_i.pos0;
    m1 = duty_mask(mix_i.duty1) >> mix_i.pos1;
    wv = mix_i.wave_nib >> wave_shift(mix_i.wave_lvl);
    v[0] = mix_i.chan_on[0] ? (m0[0] ? $signed({1'b0, mix_i.vol0}) :
                                       -$signed({1'b0, mix_i.vol0})) : 5'sd0;
    v[1] = mix_i.chan_on[1] ? (m1[0] ? $signed({1'b0, mix_i.vol1}) :
                                       -$signed({1'b0, mix_i.vol1})) : 5'sd0;
    v[2] = mix_i.chan_on[2] ? $signed({1'b0, wv}) : 5'sd0;
    v[3] = mix_i.chan_on[3] ? (mix_i.noise_bit ? $signed({1'b0, mix_i.vol2}) :
                                                 -$signed({1'b0, mix_i.vol2})) : 5'sd0;
    lsum = 7'sd0;
    rsum = 7'sd0;
    for (int c = 0; c < 4; c++) begin
      if (mix_i.pan[c+4]) lsum = lsum + 7'(v[c]);
      if (mix_i.pan[c])   rsum = rsum + 7'(v[c]);
    end
    lprod = lsum * $signed({2'b0, {1'b0, mix_i.mvol[6:4]} + 4'd1});
    rprod = rsum * $signed({2'b0, {1'b0, mix_i.mvol[2:0]} + 4'd1});
    left_o  = mix_i.master_on ? lprod[9:0] : 10'sd0;
    right_o = mix_i.master_on ? rprod[9:0] : 10'sd0;
  end

endmodule
`default_nettype wire

// File: hdl/fcsg_core.sv
// Register file and channel state: bus access, frame sequencer and per-step counters.
`default_nettype none
module fcsg_core #(
  parameter int SampleInterval = fcsg_pkg::SampleIntervalDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [1:0]        op_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  output logic [7:0]        read_data_o,
  output logic              sample_valid_o,
  output fcsg_pkg::fcsg_mix_t mix_o
);
  import fcsg_pkg::*;

  logic [7:0] p1_sweep_q, p1_len_q, p1_env_q, p1_lo_q, p1_hi_q;
  logic [7:0] p1_sweep_d, p1_len_d, p1_env_d, p1_lo_d, p1_hi_d;
  logic [7:0] p2_len_q, p2_env_q, p2_lo_q, p2_hi_q;
  logic [7:0] p2_len_d, p2_env_d, p2_lo_d, p2_hi_d;
  logic [7:0] w_ctl_q, w_len_q, w_lvl_q, w_lo_q, w_hi_q;
  logic [7:0] w_ctl_d, w_len_d, w_lvl_d, w_lo_d, w_hi_d;
  logic [7:0] n_len_q, n_env_q, n_frq_q, n_ctl_q;
  logic [7:0] n_len_d, n_env_d, n_frq_d, n_ctl_d;
  logic [7:0] mctl_q, mctl_d, pan_q, pan_d, mvol_q, mvol_d;
  logic [7:0] wram_q [WaveRamBytes];
  logic [7:0] wram_d [WaveRamBytes];
  logic [21:0] per_q [4];
  logic [21:0] per_d [4];
  logic [4:0] duty_q [3];
  logic [4:0] duty_d [3];
  logic [8:0] len_q [4];
  logic [8:0] len_d [4];
  logic [2:0] envt_q [3];
  logic [2:0] envt_d [3];
  logic [3:0] vol_q [3];
  logic [3:0] vol_d [3];
  logic [10:0] shadow_q, shadow_d;
  logic [3:0]  swt_q, swt_d;
  logic        swact_q, swact_d;
  logic [14:0] lfsr_q, lfsr_d;
  logic [1:0]  phase_q, phase_d;
  logic [6:0]  cnt_q, cnt_d;

  always_comb begin
    logic [7:0]  env [3];
    logic [3:0]  lcount;
    logic [2:0]  per, sh;
    logic [11:0] nxt, delta;
    logic [10:0] frq [3];
    logic [11:0] span;
    logic [21:0] pt;
    logic        nbit;
    logic [14:0] nl;

    p1_sweep_d = p1_sweep_q; p1_len_d = p1_len_q; p1_env_d = p1_env_q;
    p1_lo_d = p1_lo_q; p1_hi_d = p1_hi_q;
    p2_len_d = p2_len_q; p2_env_d = p2_env_q; p2_lo_d = p2_lo_q; p2_hi_d = p2_hi_q;
    w_ctl_d = w_ctl_q; w_len_d = w_len_q; w_lvl_d = w_lvl_q; w_lo_d = w_lo_q;
    w_hi_d = w_hi_q;
    n_len_d = n_len_q; n_env_d = n_env_q; n_frq_d = n_frq_q; n_ctl_d = n_ctl_q;
    mctl_d = mctl_q; pan_d = pan_q; mvol_d = mvol_q;
    wram_d = wram_q; per_d = per_q; duty_d = duty_q; len_d = len_q;
    envt_d = envt_q; vol_d = vol_q;
    shadow_d = shadow_q; swt_d = swt_q; swact_d = swact_q; lfsr_d = lfsr_q;
    phase_d = phase_q; cnt_d = cnt_q;
    read_data_o = 8'h00;
    sample_valid_o = 1'b0;
    env[0] = p1_env_q; env[1] = p2_env_q; env[2] = n_env_q;
    lcount = {n_ctl_q[6], w_hi_q[6], p2_hi_q[6], p1_hi_q[6]};
    per = p1_sweep_q[6:4];
    sh = p1_sweep_q[2:0];
    nxt = '0;
    delta = '0;
    frq[0] = {p1_hi_q[2:0], p1_lo_q};
    frq[1] = {p2_hi_q[2:0], p2_lo_q};
    frq[2] = {w_hi_q[2:0], w_lo_q};
    span = '0;
    pt = '0;
    nbit = 1'b0;
    nl = '0;

    case (op_i)
      OpRead: begin
        if (address_i[15:4] == AddrWaveRam) begin
          read_data_o = wram_q[address_i[3:0]];
        end else begin
          case (address_i)
            AddrP1Sweep: read_data_o = p1_sweep_q;
            AddrP1Len:   read_data_o = p1_len_q;
            AddrP1Env:   read_data_o = p1_env_q;
            AddrP1Hi:    read_data_o = p1_hi_q;
            AddrP2Len:   read_data_o = p2_len_q;
            AddrP2Env:   read_data_o = p2_env_q;
            AddrP2Hi:    read_data_o = p2_hi_q;
            AddrWCtl:    read_data_o = w_ctl_q;
            AddrWLen:    read_data_o = w_len_q;
            AddrWLvl:    read_data_o = w_lvl_q;
            AddrWHi:     read_data_o = w_hi_q;
            AddrNLen:    read_data_o = n_len_q;
            AddrNEnv:    read_data_o = n_env_q;
            AddrNFrq:    read_data_o = n_frq_q;
            AddrNCtl:    read_data_o = n_ctl_q;
            AddrVolume:  read_data_o = mvol_q;
            AddrPanning: read_data_o = pan_q;
            AddrMaster:  read_data_o = mctl_q;
            default:     read_data_o = 8'hFF;
          endcase
        end
      end
      OpWrite: begin
        if (address_i == AddrMaster) begin
          mctl_d = {write_data_i[7], mctl_q[6:0]};
          if (!write_data_i[7]) begin
            // Power-off clears every channel register, the wave RAM and the status bits.
            mctl_d = {1'b0, mctl_q[6:4], 4'h0};
            p1_sweep_d = '0; p1_len_d = '0; p1_env_d = '0; p1_lo_d = '0; p1_hi_d = '0;
            p2_len_d = '0; p2_env_d = '0; p2_lo_d = '0; p2_hi_d = '0;
            w_ctl_d = '0; w_len_d = '0; w_lvl_d = '0; w_lo_d = '0; w_hi_d = '0;
            n_len_d = '0; n_env_d = '0; n_frq_d = '0; n_ctl_d = '0;
            for (int i = 0; i < WaveRamBytes; i++) wram_d[i] = '0;
            for (int i = 0; i < 4; i++) begin
              per_d[i] = '0;
              len_d[i] = '0;
            end
            for (int i = 0; i < 3; i++) begin
              duty_d[i] = '0;
              envt_d[i] = '0;
              vol_d[i] = '0;
            end
            shadow_d = '0; swt_d = '0; swact_d = 1'b0; lfsr_d = '0;
          end
        end else if (mctl_q[7]) begin
          if (address_i[15:4] == AddrWaveRam) begin
            wram_d[address_i[3:0]] = write_data_i;
          end else begin
            case (address_i)
              AddrP1Sweep: p1_sweep_d = write_data_i | 8'h80;
              AddrP1Len:   p1_len_d = write_data_i;
              AddrP1Env:   p1_env_d = write_data_i;
              AddrP1Lo:    p1_lo_d = write_data_i;
              AddrP1Hi: begin
                p1_hi_d = write_data_i | 8'h38;
                if (write_data_i[7]) begin
                  envt_d[0] = p1_env_q[2:0];
                  len_d[0] = 9'd64 - {3'b0, p1_len_q[5:0]};
                  swact_d = (per != 3'd0) || (sh != 3'd0);
                  shadow_d = {write_data_i[2:0], p1_lo_q};
                  swt_d = (per != 3'd0) ? {1'b0, per} : 4'd8;
                  vol_d[0] = p1_env_q[7:4];
                  mctl_d[0] = 1'b1;
                end
              end
              AddrP2Len: p2_len_d = write_data_i;
              AddrP2Env: p2_env_d = write_data_i;
              AddrP2Lo:  p2_lo_d = write_data_i;
              AddrP2Hi: begin
                p2_hi_d = write_data_i | 8'h38;
                if (write_data_i[7]) begin
                  envt_d[1] = p2_env_q[2:0];
                  len_d[1] = 9'd64 - {3'b0, p2_len_q[5:0]};
                  vol_d[1] = p2_env_q[7:4];
                  mctl_d[1] = 1'b1;
                end
              end
              AddrWCtl: begin
                w_ctl_d = write_data_i | 8'h7F;
                if (!write_data_i[7]) mctl_d[2] = 1'b0;
              end
              AddrWLen: w_len_d = write_data_i;
              AddrWLvl: w_lvl_d = write_data_i | 8'h9F;
              AddrWLo:  w_lo_d = write_data_i;
              AddrWHi: begin
                w_hi_d = write_data_i | 8'h38;
                if (write_data_i[7]) begin
                  duty_d[2] = '0;
                  len_d[2] = 9'd256 - {1'b0, w_len_q};
                  mctl_d[2] = 1'b1;
                end
              end
              AddrNLen: n_len_d = write_data_i | 8'hC0;
              AddrNEnv: n_env_d = write_data_i;
              AddrNFrq: n_frq_d = write_data_i;
              AddrNCtl: begin
                n_ctl_d = write_data_i | 8'h3F;
                if (write_data_i[7]) begin
                  lfsr_d = '0;
                  envt_d[2] = n_env_q[2:0];
                  len_d[3] = 9'd64 - {3'b0, n_len_q[5:0]};
                  vol_d[2] = n_env_q[7:4];
                  mctl_d[3] = 1'b1;
                end
              end
              AddrVolume:  mvol_d = write_data_i;
              AddrPanning: pan_d = write_data_i;
              default: ;
            endcase
          end
        end
      end
      OpFrame: begin
        for (int c = 0; c < 4; c++) begin
          if (lcount[c] && len_q[c] != 9'd0) begin
            len_d[c] = len_q[c] - 9'd1;
            if (len_q[c] == 9'd1) mctl_d[c] = 1'b0;
          end
        end
        if (!phase_q[0] && swt_q != 4'd0) begin
          swt_d = swt_q - 4'd1;
          if (swt_q == 4'd1) begin
            swt_d = (per != 3'd0) ? {1'b0, per} : 4'd8;
            if (swact_q && per != 3'd0) begin
              delta = {1'b0, shadow_q >> sh};
              nxt = p1_sweep_q[3] ? ({1'b0, shadow_q} - delta) : ({1'b0, shadow_q} + delta);
              if (nxt > 12'd2047) begin
                swact_d = 1'b0;
                mctl_d[0] = 1'b0;
              end else if (sh != 3'd0) begin
                p1_hi_d = {p1_hi_q[7:3], nxt[10:8]};
                p1_lo_d = nxt[7:0];
                shadow_d = nxt[10:0];
              end
            end
          end
        end
        if (phase_q == 2'd0) begin
          for (int k = 0; k < 3; k++) begin
            if (envt_q[k] != 3'd0) begin
              envt_d[k] = envt_q[k] - 3'd1;
              if (envt_q[k] == 3'd1) begin
                envt_d[k] = env[k][2:0];
                if (env[k][3]) begin
                  if (vol_q[k] != 4'd15) vol_d[k] = vol_q[k] + 4'd1;
                end else if (vol_q[k] != 4'd0) begin
                  vol_d[k] = vol_q[k] - 4'd1;
                end
              end
            end
          end
        end
        phase_d = phase_q + 2'd1;
      end
      default: begin
        for (int c = 0; c < 3; c++) begin
          if (mctl_q[c]) begin
            span = 12'd2048 - {1'b0, frq[c]};
            pt = per_q[c];
            if (per_q[c] == 22'd0) begin
              pt = (c == 2) ? {9'b0, span, 1'b0} : {8'b0, span, 2'b0};
              duty_d[c] = (c == 2) ? duty_q[c] + 5'd1 : {2'b0, duty_q[c][2:0] + 3'd1};
            end
            per_d[c] = pt - 22'd1;
          end
        end
        if (mctl_q[3]) begin
          pt = per_q[3];
          if (per_q[3] == 22'd0) begin
            nbit = ~(lfsr_q[0] ^ lfsr_q[1]);
            pt = {15'b0, noise_div(n_frq_q[2:0])} << n_frq_q[7:4];
            nl = {nbit, lfsr_q[14:1]};
            if (n_frq_q[3]) nl[6] = nbit;
            lfsr_d = nl;
          end
          per_d[3] = pt - 22'd1;
        end
        if (cnt_q == 7'd0) begin
          sample_valid_o = 1'b1;
          cnt_d = 7'(SampleInterval - 1);
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
    endcase
  end

  // The mixer sees the state as it stands after this step's counters have moved.
  always_comb begin
    logic [7:0] wb;
    wb = wram_q[duty_d[2][4:1]];
    mix_o.master_on = mctl_q[7];
    mix_o.chan_on   = mctl_q[3:0];
    mix_o.pan       = pan_q;
    mix_o.mvol      = mvol_q;
    mix_o.duty0     = p1_len_q[7:6];
    mix_o.duty1     = p2_len_q[7:6];
    mix_o.pos0      = duty_d[0][2:0];
    mix_o.pos1      = duty_d[1][2:0];
    mix_o.vol0      = vol_q[0];
    mix_o.vol1      = vol_q[1];
    mix_o.vol2      = vol_q[2];
    mix_o.wave_nib  = duty_d[2][0] ? wb[3:0] : wb[7:4];
    mix_o.wave_lvl  = w_lvl_q[6:5];
    mix_o.noise_bit = lfsr_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_sweep_q <= 8'h80; p1_len_q <= '0; p1_env_q <= '0; p1_lo_q <= '0;
      p1_hi_q <= 8'h38;
      p2_len_q <= '0; p2_env_q <= '0; p2_lo_q <= '0; p2_hi_q <= 8'h38;
      w_ctl_q <= 8'h7F; w_len_q <= '0; w_lvl_q <= 8'h9F; w_lo_q <= '0; w_hi_q <= 8'h38;
      n_len_q <= 8'hC0; n_env_q <= '0; n_frq_q <= '0; n_ctl_q <= 8'h3F;
      mctl_q <= 8'h70; pan_q <= '0; mvol_q <= 8'h88;
      for (int i = 0; i < WaveRamBytes; i++) wram_q[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        per_q[i] <= '0;
        len_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        duty_q[i] <= '0;
        envt_q[i] <= '0;
        vol_q[i] <= '0;
      end
      shadow_q <= '0; swt_q <= '0; swact_q <= 1'b0; lfsr_q <= '0;
      phase_q <= '0; cnt_q <= '0;
    end else if (fire_i) begin
      p1_sweep_q <= p1_sweep_d; p1_len_q <= p1_len_d; p1_env_q <= p1_env_d;
      p1_lo_q <= p1_lo_d; p1_hi_q <= p1_hi_d;
      p2_len_q <= p2_len_d; p2_env_q <= p2_env_d; p2_lo_q <= p2_lo_d; p2_hi_q <= p2_hi_d;
      w_ctl_q <= w_ctl_d; w_len_q <= w_len_d; w_lvl_q <= w_lvl_d; w_lo_q <= w_lo_d;
      w_hi_q <= w_hi_d;
      n_len_q <= n_len_d; n_env_q <= n_env_d; n_frq_q <= n_frq_d; n_ctl_q <= n_ctl_d;
      mctl_q <= mctl_d; pan_q <= pan_d; mvol_q <= mvol_d;
      wram_q <= wram_d; per_q <= per_d; duty_q <= duty_d; len_q <= len_d;
      envt_q <= envt_d; vol_q <= vol_d;
      shadow_q <= shadow_d; swt_q <= swt_d; swact_q <= swact_d; lfsr_q <= lfsr_d;
      phase_q <= phase_d; cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> (op_i == OpStep))
    else $error("sample outside a machine step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mctl_q[7] |-> (mctl_q[3:0] == 4'h0))
    else $error("channel active while powered off");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    swt_q <= 4'd8)
    else $error("sweep timer out of range");

endmodule
`default_nettype wire

// File: tb/four_channel_sound_generator_checker.sv
// Checker for the four-channel sound generator: predicts every result and compares it.
`timescale 1ns / 100ps
module four_channel_sound_generator_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] op_i,
  input  logic [15:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] read_data_i,
  input  logic       sample_valid_i,
  input  logic [9:0] left_mix_i,
  input  logic [9:0] right_mix_i,
  output int         fail_count_o,
  output int         pending_o
);
  import fcsg_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sample_valid;
    logic [9:0] left_mix;
    logic [9:0] right_mix;
  } sound_result_t;

  // Register slots inside each channel's register group.
  localparam int PLen = 0, PEnv = 1, PLo = 2, PHi = 3, PSweep = 4;
  localparam int WCtl = 0, WLen = 1, WLvl = 2, WLo = 3, WHi = 4;
  localparam int NLen = 0, NEnv = 1, NFrq = 2, NCtl = 3;

  localparam int unsigned NoiseBase [8] = '{8, 16, 32, 48, 64, 80, 96, 112};
  localparam int unsigned LevelShift [4] = '{4, 0, 1, 2};
  localparam logic [7:0] DutyPattern [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

  logic [7:0]  p1_reg [5];
  logic [7:0]  p2_reg [4];
  logic [7:0]  wave_reg [5];
  logic [7:0]  noise_reg [4];
  logic [7:0]  master_ctl, pan_reg, vol_reg;
  logic [7:0]  wave_mem [16];
  int unsigned period_cnt [4];
  logic [4:0]  position [3];
  int unsigned length_cnt [4];
  logic [2:0]  env_timer [3];
  logic [3:0]  chan_vol [3];
  logic [15:0] sweep_freq;
  logic [3:0]  sweep_timer;
  logic        sweep_on;
  logic [14:0] lfsr;
  logic [1:0]  frame_phase;
  logic [6:0]  sample_cnt;

  sound_result_t expected_results [$];

  function automatic logic [10:0] freq_of(input logic [7:0] lo, input logic [7:0] hi);
    return {hi[2:0], lo};
  endfunction

  function automatic void silence_channels();
    for (int i = 0; i < 5; i++) begin
      p1_reg[i] = '0;
      wave_reg[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      p2_reg[i] = '0;
      noise_reg[i] = '0;
      period_cnt[i] = 0;
      length_cnt[i] = 0;
    end
    for (int i = 0; i < 16; i++) wave_mem[i] = '0;
    for (int i = 0; i < 3; i++) begin
      position[i] = '0;
      env_timer[i] = '0;
      chan_vol[i] = '0;
    end
    sweep_freq = '0;
    sweep_timer = '0;
    sweep_on = 1'b0;
    lfsr = '0;
  endfunction

  function automatic void power_on_state();
    silence_channels();
    p1_reg[PSweep] = 8'h80;
    p1_reg[PHi] = 8'h38;
    p2_reg[PHi] = 8'h38;
    wave_reg[WCtl] = 8'h7F;
    wave_reg[WHi] = 8'h38;
    wave_reg[WLvl] = 8'h9F;
    noise_reg[NCtl] = 8'h3F;
    noise_reg[NLen] = 8'hC0;
    master_ctl = 8'h70;
    pan_reg = '0;
    vol_reg = 8'h88;
    frame_phase = '0;
    sample_cnt = '0;
  endfunction

  function automatic logic [7:0] read_reg(input logic [15:0] a);
    if (a[15:4] == AddrWaveRam) return wave_mem[a[3:0]];
    case (a)
      AddrP1Sweep: return p1_reg[PSweep];
      AddrP1Len:   return p1_reg[PLen];
      AddrP1Env:   return p1_reg[PEnv];
      AddrP1Hi:    return p1_reg[PHi];
      AddrP2Len:   return p2_reg[PLen];
      AddrP2Env:   return p2_reg[PEnv];
      AddrP2Hi:    return p2_reg[PHi];
      AddrWCtl:    return wave_reg[WCtl];
      AddrWLen:    return wave_reg[WLen];
      AddrWLvl:    return wave_reg[WLvl];
      AddrWHi:     return wave_reg[WHi];
      AddrNLen:    return noise_reg[NLen];
      AddrNEnv:    return noise_reg[NEnv];
      AddrNFrq:    return noise_reg[NFrq];
      AddrNCtl:    return noise_reg[NCtl];
      AddrVolume:  return vol_reg;
      AddrPanning: return pan_reg;
      AddrMaster:  return master_ctl;
      default:     return 8'hFF;
    endcase
  endfunction

  function automatic void write_reg(input logic [15:0] a, input logic [7:0] d);
    logic [2:0] per;
    if (a == AddrMaster) begin
      master_ctl[7] = d[7];
      if (!d[7]) begin
        silence_channels();
        master_ctl[3:0] = '0;
      end
      return;
    end
    if (!master_ctl[7]) return;
    if (a[15:4] == AddrWaveRam) begin
      wave_mem[a[3:0]] = d;
      return;
    end
    case (a)
      AddrP1Sweep: p1_reg[PSweep] = d | 8'h80;
      AddrP1Len:   p1_reg[PLen] = d;
      AddrP1Env:   p1_reg[PEnv] = d;
      AddrP1Lo:    p1_reg[PLo] = d;
      AddrP1Hi: begin
        p1_reg[PHi] = d | 8'h38;
        if (d[7]) begin
          per = p1_reg[PSweep][6:4];
          env_timer[0] = p1_reg[PEnv][2:0];
          length_cnt[0] = 64 - p1_reg[PLen][5:0];
          sweep_on = (per != 0) || (p1_reg[PSweep][2:0] != 0);
          sweep_freq = {5'd0, freq_of(p1_reg[PLo], p1_reg[PHi])};
          sweep_timer = (per != 0) ? {1'b0, per} : 4'd8;
          chan_vol[0] = p1_reg[PEnv][7:4];
          master_ctl[0] = 1'b1;
        end
      end
      AddrP2Len: p2_reg[PLen] = d;
      AddrP2Env: p2_reg[PEnv] = d;
      AddrP2Lo:  p2_reg[PLo] = d;
      AddrP2Hi: begin
        p2_reg[PHi] = d | 8'h38;
        if (d[7]) begin
          env_timer[1] = p2_reg[PEnv][2:0];
          length_cnt[1] = 64 - p2_reg[PLen][5:0];
          chan_vol[1] = p2_reg[PEnv][7:4];
          master_ctl[1] = 1'b1;
        end
      end
      AddrWCtl: begin
        wave_reg[WCtl] = d | 8'h7F;
        if (!d[7]) master_ctl[2] = 1'b0;
      end
      AddrWLen: wave_reg[WLen] = d;
      AddrWLvl: wave_reg[WLvl] = d | 8'h9F;
      AddrWLo:  wave_reg[WLo] = d;
      AddrWHi: begin
        wave_reg[WHi] = d | 8'h38;
        if (d[7]) begin
          position[2] = '0;
          length_cnt[2] = 256 - wave_reg[WLen];
          master_ctl[2] = 1'b1;
        end
      end
      AddrNLen: noise_reg[NLen] = d | 8'hC0;
      AddrNEnv: noise_reg[NEnv] = d;
      AddrNFrq: noise_reg[NFrq] = d;
      AddrNCtl: begin
        noise_reg[NCtl] = d | 8'h3F;
        if (d[7]) begin
          lfsr = '0;
          env_timer[2] = noise_reg[NEnv][2:0];
          length_cnt[3] = 64 - noise_reg[NLen][5:0];
          chan_vol[2] = noise_reg[NEnv][7:4];
          master_ctl[3] = 1'b1;
        end
      end
      AddrVolume:  vol_reg = d;
      AddrPanning: pan_reg = d;
      default: ;
    endcase
  endfunction

  function automatic void envelope_step(input int k, input logic [7:0] env);
    if (env_timer[k] == 0) return;
    env_timer[k]--;
    if (env_timer[k] != 0) return;
    env_timer[k] = env[2:0];
    if (env[3]) begin
      if (chan_vol[k] < 15) chan_vol[k]++;
    end else if (chan_vol[k] > 0) begin
      chan_vol[k]--;
    end
  endfunction

  function automatic void length_step(input int c, input logic counting);
    if (counting && length_cnt[c] != 0) begin
      length_cnt[c]--;
      if (length_cnt[c] == 0) master_ctl[c] = 1'b0;
    end
  endfunction

  function automatic void sweep_step();
    logic [2:0]  per, sh;
    logic [15:0] delta, next_freq;
    per = p1_reg[PSweep][6:4];
    sh = p1_reg[PSweep][2:0];
    if (sweep_timer == 0) return;
    sweep_timer--;
    if (sweep_timer != 0) return;
    sweep_timer = (per != 0) ? {1'b0, per} : 4'd8;
    if (!sweep_on || per == 0) return;
    delta = sweep_freq >> sh;
    next_freq = p1_reg[PSweep][3] ? sweep_freq - delta : sweep_freq + delta;
    if (next_freq > 2047) begin
      sweep_on = 1'b0;
      master_ctl[0] = 1'b0;
    end else if (sh != 0) begin
      p1_reg[PHi] = {p1_reg[PHi][7:3], next_freq[10:8]};
      p1_reg[PLo] = next_freq[7:0];
      sweep_freq = next_freq;
    end
  endfunction

  function automatic void frame_step();
    length_step(0, p1_reg[PHi][6]);
    length_step(1, p2_reg[PHi][6]);
    length_step(2, wave_reg[WHi][6]);
    length_step(3, noise_reg[NCtl][6]);
    if (!frame_phase[0]) sweep_step();
    if (frame_phase == 0) begin
      envelope_step(0, p1_reg[PEnv]);
      envelope_step(1, p2_reg[PEnv]);
      envelope_step(2, noise_reg[NEnv]);
    end
    frame_phase++;
  endfunction

  function automatic void tone_step(input int c, input logic [10:0] f, input int unsigned mult,
                                    input logic [4:0] wrap);
    if (!master_ctl[c]) return;
    if (period_cnt[c] == 0) begin
      period_cnt[c] = (2048 - f) * mult;
      position[c] = (position[c] + 5'd1) & wrap;
    end
    period_cnt[c]--;
  endfunction

  function automatic void noise_step();
    logic [7:0] f;
    logic       fb;
    if (!master_ctl[3]) return;
    if (period_cnt[3] == 0) begin
      f = noise_reg[NFrq];
      fb = ~(lfsr[0] ^ lfsr[1]);
      period_cnt[3] = NoiseBase[f[2:0]] << f[7:4];
      lfsr = {fb, lfsr[14:1]};
      if (f[3]) lfsr[6] = fb;
    end
    period_cnt[3]--;
  endfunction

  function automatic int pulse_level(input int c, input logic [1:0] duty);
    logic [7:0] pattern;
    pattern = DutyPattern[duty] >> position[c][2:0];
    return pattern[0] ? int'(chan_vol[c]) : -int'(chan_vol[c]);
  endfunction

  function automatic int wave_level();
    logic [7:0] b;
    logic [3:0] nib;
    b = wave_mem[position[2][4:1]];
    nib = position[2][0] ? b[3:0] : b[7:4];
    return int'(nib) >> LevelShift[wave_reg[WLvl][6:5]];
  endfunction

  function automatic sound_result_t predict_request(input logic [1:0] op, input logic [15:0] a,
                                                    input logic [7:0] d);
    sound_result_t r;
    int lvl [4];
    int l, rr;
    r = '0;
    l = 0;
    rr = 0;
    case (op)
      OpRead:  r.read_data = read_reg(a);
      OpWrite: write_reg(a, d);
      OpFrame: frame_step();
      default: begin
        tone_step(0, freq_of(p1_reg[PLo], p1_reg[PHi]), 4, 5'd7);
        tone_step(1, freq_of(p2_reg[PLo], p2_reg[PHi]), 4, 5'd7);
        tone_step(2, freq_of(wave_reg[WLo], wave_reg[WHi]), 2, 5'd31);
        noise_step();
        if (sample_cnt == 0) begin
          if (master_ctl[7]) begin
            lvl[0] = master_ctl[0] ? pulse_level(0, p1_reg[PLen][7:6]) : 0;
            lvl[1] = master_ctl[1] ? pulse_level(1, p2_reg[PLen][7:6]) : 0;
            lvl[2] = master_ctl[2] ? wave_level() : 0;
            lvl[3] = !master_ctl[3] ? 0 : (lfsr[0] ? int'(chan_vol[2]) : -int'(chan_vol[2]));
            for (int c = 0; c < 4; c++) begin
              if (pan_reg[c + 4]) l += lvl[c];
              if (pan_reg[c]) rr += lvl[c];
            end
            l *= int'(vol_reg[6:4]) + 1;
            rr *= int'(vol_reg[2:0]) + 1;
          end
          r.sample_valid = 1'b1;
          r.left_mix = l[9:0];
          r.right_mix = rr[9:0];
          sample_cnt = 7'(SampleIntervalDef);
        end
        sample_cnt--;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sound_result_t want;
    if (!rst_ni) begin
      power_on_state();
      expected_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Retire the result first so a request taken at the same edge queues behind it.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%h sample_valid=%b left=%h right=%h",
                   $time, read_data_i, sample_valid_i, left_mix_i, right_mix_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== {read_data_i, sample_valid_i, left_mix_i, right_mix_i}) begin
            $display("%0t: mismatch expected rd=%h sv=%b l=%h r=%h, got rd=%h sv=%b l=%h r=%h",
                     $time, want.read_data, want.sample_valid, want.left_mix,
                     want.right_mix, read_data_i, sample_valid_i, left_mix_i, right_mix_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(predict_request(op_i, address_i, write_data_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: tb/four_channel_sound_generator_tb.sv
// Testbench top for the four-channel sound generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module four_channel_sound_generator_tb;
  import fcsg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = OpRead;
  logic [15:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        sample_valid_o;
  logic signed [9:0] left_mix_o, right_mix_o;

  int   fail_count, pending;
  logic request_taken = 1'b0;
  logic calm = 1'b0;
  int   holds_asked = 0;
  int   holds_done = 0;

  localparam logic [15:0] SoundRegs [21] = '{
    AddrP1Sweep, AddrP1Len, AddrP1Env, AddrP1Lo, AddrP1Hi, AddrP2Len, AddrP2Env,
    AddrP2Lo, AddrP2Hi, AddrWCtl, AddrWLen, AddrWLvl, AddrWLo, AddrWHi, AddrNLen,
    AddrNEnv, AddrNFrq, AddrNCtl, AddrVolume, AddrPanning, AddrMaster};

  always #5 clk_i = ~clk_i;

  four_channel_sound_generator u_dut (.*);

  four_channel_sound_generator_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .address_i,
    .write_data_i, .out_valid_i(out_valid_o), .out_ready_i, .read_data_i(read_data_o),
    .sample_valid_i(sample_valid_o), .left_mix_i(left_mix_o), .right_mix_i(right_mix_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) request_taken <= in_valid_i && in_ready_o;

  function automatic int gap_length();
    if (calm || $urandom_range(0, 99) < 70) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (holds_asked != holds_done) begin
        out_ready_i = 1'b0;
        repeat (40) @(negedge clk_i);
        holds_done++;
      end
      if (stall == 0) stall = gap_length();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    address_i = a;
    write_data_i = d;
    do @(negedge clk_i); while (!request_taken);
  endtask

  task automatic write_reg(input logic [15:0] a, input logic [7:0] d);
    send(OpWrite, a, d);
  endtask

  task automatic read_reg(input logic [15:0] a);
    send(OpRead, a, 8'($urandom));
  endtask

  task automatic steps(input int n);
    repeat (n) send(OpStep, 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic random_request();
    int pick;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    d = 8'($urandom);
    if (pick < 55) begin
      steps(1);
    end else if (pick < 65) begin
      send(OpFrame, 16'($urandom), d);
    end else if (pick < 85) begin
      a = ($urandom_range(0, 3) == 0) ? {AddrWaveRam, 4'($urandom)}
                                       : SoundRegs[$urandom_range(0, 20)];
      // Power-off should be occasional so most writes land on a live block.
      if (a == AddrMaster && $urandom_range(0, 3) != 0) d[7] = 1'b1;
      write_reg(a, d);
    end else if (pick < 95) begin
      read_reg(($urandom_range(0, 1) == 0) ? SoundRegs[$urandom_range(0, 20)]
                                           : {AddrWaveRam, 4'($urandom)});
    end else begin
      send(2'($urandom), 16'($urandom), d);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Power-on values, writes ignored while off, then power up.
    read_reg(AddrMaster);
    read_reg(AddrWLvl);
    write_reg(AddrP1Len, 8'hFF);
    read_reg(AddrP1Len);
    write_reg(AddrMaster, 8'h80);
    write_reg(AddrVolume, 8'h77);
    write_reg(AddrPanning, 8'hFF);
    // Pulse one at top frequency with an upward sweep that must overflow.
    write_reg(AddrP1Env, 8'hF3);
    write_reg(AddrP1Sweep, 8'h11);
    write_reg(AddrP1Lo, 8'hFF);
    write_reg(AddrP1Hi, 8'h87);
    send(OpFrame, '0, '0);
    read_reg(AddrMaster);
    write_reg(16'hFF30, 8'hF0);
    write_reg(AddrWCtl, 8'h80);
    write_reg(AddrWLvl, 8'h20);
    write_reg(AddrWHi, 8'hC7);
    write_reg(AddrNEnv, 8'hF8);
    write_reg(AddrNCtl, 8'h80);
    read_reg(16'hFF3F);
    read_reg(16'h0000);
    read_reg(AddrP1Lo);
    write_reg(16'hFFFF, 8'h00);
    steps(90);
    write_reg(AddrMaster, 8'h00);
    read_reg(16'hFF30);
    write_reg(AddrMaster, 8'h80);
    write_reg(AddrVolume, 8'h00);

    for (int i = 0; i < 330; i++) begin
      if (i == 110) holds_asked++;
      if (i == 220) drain();
      calm = (i >= 250 && i < 310);
      random_request();
    end
    drain();
    repeat (5) @(negedge clk_i);
    if (fail_count == 0) $display("four_channel_sound_generator_tb: PASS");
    else $display("four_channel_sound_generator_tb: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("four_channel_sound_generator_tb: FAIL");
    $finish;
  end

endmodule
